// ----- sv/swlc_pkg.sv -----
// swlc_pkg: shared types and codes for the sliding window live cell counter
// holds the channel payload structs, command and status codes, register map
// no dependencies; used by the channel interface users and the top level
package swlc_pkg;

  // default sizing of the grid and the counted square
  localparam int DEF_CHUNK_SIDE    = 16;
  localparam int DEF_CHUNKS_ACROSS = 4;
  localparam int DEF_CHUNKS_DOWN   = 4;
  localparam int DEF_MAX_RADIUS    = 4;

  // command codes
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_RIGHT = 3'd2;
  localparam logic [2:0] CMD_LEFT  = 3'd3;
  localparam logic [2:0] CMD_DOWN  = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_COORD = 2'd1;
  localparam logic [1:0] STAT_NOT_SET   = 2'd2;
  localparam logic [1:0] STAT_EDGE      = 2'd3;

  // register map: one 32-bit register per word
  localparam int         ADDR_W      = 3;
  localparam logic [0:0] REG_RADIUS  = 1'b0;
  localparam logic [2:0] RADIUS_RST  = 3'd1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] chunk_col;
    logic [1:0] chunk_row;
    logic       cell_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0] live_count;
    logic [3:0] cursor_x;
    logic [3:0] cursor_y;
    logic [1:0] status;
  } out_item_t;

endpackage

// ----- sv/swlc_chan_if.sv -----
// swlc_chan_if: valid/ready channel carrying one payload item per transfer
// payload type is set per instance, normally a struct from swlc_pkg
// no other dependencies
interface swlc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/sliding_window_live_cell_count.sv -----
// sliding_window_live_cell_count: live count of the square around a cursor on a chunked grid
// depends on swlc_pkg (types, codes) and swlc_chan_if (input and result channels)
// single module: sequencer, one probe adder/compare unit, row-organized cell memory
//
//   channel   dir   handshake            payload
//   in_ch     in    valid/ready          swlc_pkg::in_item_t (command, cell, chunk, value)
//   out_ch    out   valid/ready          swlc_pkg::out_item_t (count, cursor, status)
//   apb       in    psel/penable/pready  radius register at byte address 0
//
// write cell: row read, row write, then result; error or unknown command goes straight to the result
// set cursor: full recount of the square, one cell probe per cycle through the memory read port
// step: entering and leaving lines, then the two centres; a radius write while idle with the cursor set recounts
// after reset a clearing pass writes one grid row per cycle until every grid row is cleared
// a finished result waits in the output register; the next item is taken meanwhile
module sliding_window_live_cell_count #(
  parameter int CHUNK_SIDE    = swlc_pkg::DEF_CHUNK_SIDE,
  parameter int CHUNKS_ACROSS = swlc_pkg::DEF_CHUNKS_ACROSS,
  parameter int CHUNKS_DOWN   = swlc_pkg::DEF_CHUNKS_DOWN,
  parameter int MAX_RADIUS    = swlc_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  swlc_chan_if.sink                   in_ch,
  swlc_chan_if.source                 out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swlc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int GRID_W = CHUNKS_ACROSS * CHUNK_SIDE;
  localparam int GRID_H = CHUNKS_DOWN * CHUNK_SIDE;
  localparam int GX_W   = $clog2(GRID_W);
  localparam int GY_W   = $clog2(GRID_H);
  localparam int LOC_W  = $clog2(CHUNK_SIDE);
  localparam int CC_W   = (CHUNKS_ACROSS > 1) ? $clog2(CHUNKS_ACROSS) : 1;
  localparam int CR_W   = (CHUNKS_DOWN > 1) ? $clog2(CHUNKS_DOWN) : 1;
  localparam int SPAN   = ((GRID_W > GRID_H) ? GRID_W : GRID_H) + 2 * MAX_RADIUS + 2;
  localparam int SC_W   = $clog2(SPAN) + 1;
  localparam int ER_W   = $clog2(MAX_RADIUS + 1);
  localparam int U_W    = $clog2(2 * MAX_RADIUS + 2);
  localparam int N_SQ   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W  = ($clog2(N_SQ) > 7) ? $clog2(N_SQ) : 7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_WR,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  swlc_pkg::in_item_t in_d;
  assign in_d = in_ch.data;

  // registers
  state_t              state_r, state_nxt;
  logic [2:0]          radius_r, radius_nxt;
  logic [LOC_W-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CC_W-1:0]     cur_col_r, cur_col_nxt;
  logic [CR_W-1:0]     cur_row_r, cur_row_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic                emit_r, emit_nxt;
  logic                mode_step_r, mode_step_nxt;
  logic                mv_left_r, mv_left_nxt, mv_down_r, mv_down_nxt;
  logic [U_W-1:0]      u_r, u_nxt, v_r, v_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                pend_in_r, pend_in_nxt;
  logic                pend_sub_r, pend_sub_nxt;
  logic [GX_W-1:0]     pend_col_r, pend_col_nxt;
  logic [GX_W-1:0]     wr_gx_r, wr_gx_nxt;
  logic [GY_W-1:0]     wr_gy_r, wr_gy_nxt;
  logic                wr_val_r, wr_val_nxt;
  logic                wr_hit_r, wr_hit_nxt;
  logic [GY_W-1:0]     clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  swlc_pkg::out_item_t out_q_r, out_q_nxt;

  // cell memory, one grid row per word
  logic [GRID_W-1:0]   mem [GRID_H];
  logic [GRID_W-1:0]   mem_q_r;
  logic                mem_we;
  logic [GY_W-1:0]     mem_wa;
  logic [GRID_W-1:0]   mem_wd;
  logic [GY_W-1:0]     rd_addr;

  // combinational helpers
  logic                cfg_wr, cfg_hit, in_fire, out_free, coords_ok;
  logic [ER_W-1:0]     er;
  logic [U_W-1:0]      two_r, v_max;
  logic signed [SC_W-1:0] cx_s, cy_s, r_s, u_s, v_s, one_s, dir_s;
  logic signed [SC_W-1:0] along_s, cross_s, dx_s, dy_s, px_s, py_s;
  logic signed [SC_W-1:0] gx_in_s, gy_in_s, ox_s, oy_s;
  logic                probe_skip, probe_sub, probe_last, probe_in, centre_phase;
  logic                old_bit;

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[swlc_pkg::ADDR_W-1:2] == swlc_pkg::REG_RADIUS);
  assign prdata  = cfg_hit ? 32'(radius_r) : 32'd0;

  // handshakes
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_wr;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_q_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // effective radius, clamped into 1..MAX_RADIUS
  always_comb begin
    if (radius_r == 3'd0) begin
      er = ER_W'(1);
    end else if (32'(radius_r) > 32'(MAX_RADIUS)) begin
      er = ER_W'(MAX_RADIUS);
    end else begin
      er = ER_W'(radius_r);
    end
  end

  assign two_r = U_W'({er, 1'b0});
  assign v_max = mode_step_r ? U_W'(1) : two_r;

  // cursor centre in grid coordinates
  assign cx_s  = $signed(SC_W'(cur_col_r) * SC_W'(CHUNK_SIDE) + SC_W'(cur_x_r));
  assign cy_s  = $signed(SC_W'(cur_row_r) * SC_W'(CHUNK_SIDE) + SC_W'(cur_y_r));
  assign r_s   = $signed(SC_W'(er));
  assign u_s   = $signed(SC_W'(u_r));
  assign v_s   = $signed(SC_W'(v_r));
  assign one_s = $signed(SC_W'(1));
  assign dir_s = mv_left_r ? -one_s : one_s;

  // probe offset generator: the shared adder/compare unit works one cell per cycle
  always_comb begin
    centre_phase = (u_r == two_r + U_W'(1));
    along_s      = '0;
    cross_s      = '0;
    probe_skip   = 1'b0;
    probe_sub    = 1'b0;
    probe_last   = 1'b0;
    if (!mode_step_r) begin
      // full recount, row by row, centre excluded
      dx_s       = v_s - r_s;
      dy_s       = u_s - r_s;
      probe_skip = (u_r == U_W'(er)) && (v_r == U_W'(er));
      probe_last = (u_r == two_r) && (v_r == two_r);
    end else begin
      // entering line adds, leaving line subtracts, then the two centres
      probe_sub  = v_r[0];
      probe_last = centre_phase && v_r[0];
      if (!centre_phase) begin
        cross_s = u_s - r_s;
        if (!v_r[0]) begin
          along_s = mv_left_r ? -(r_s + one_s) : (r_s + one_s);
        end else begin
          along_s = mv_left_r ? r_s : -r_s;
        end
      end else begin
        along_s = v_r[0] ? dir_s : '0;
      end
      if (mv_down_r) begin
        dx_s = cross_s;
        dy_s = along_s;
      end else begin
        dx_s = along_s;
        dy_s = cross_s;
      end
    end
    px_s     = cx_s + dx_s;
    py_s     = cy_s + dy_s;
    probe_in = (px_s >= 0) && (px_s < GRID_W) && (py_s >= 0) && (py_s < GRID_H) && !probe_skip;
  end

  // input coordinate check and write hit test against the counted square
  always_comb begin
    coords_ok = (32'(in_d.cell_x) < 32'(CHUNK_SIDE)) && (32'(in_d.cell_y) < 32'(CHUNK_SIDE)) &&
                (32'(in_d.chunk_col) < 32'(CHUNKS_ACROSS)) &&
                (32'(in_d.chunk_row) < 32'(CHUNKS_DOWN));
    gx_in_s   = $signed(SC_W'(in_d.chunk_col) * SC_W'(CHUNK_SIDE) + SC_W'(in_d.cell_x));
    gy_in_s   = $signed(SC_W'(in_d.chunk_row) * SC_W'(CHUNK_SIDE) + SC_W'(in_d.cell_y));
    ox_s      = gx_in_s - cx_s;
    oy_s      = gy_in_s - cy_s;
  end

  assign old_bit = mem_q_r[wr_gx_r];

  // memory port control
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = wr_gy_r;
    mem_wd  = mem_q_r;
    rd_addr = (state_r == S_WR_RD) ? wr_gy_r : py_s[GY_W-1:0];
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (state_r == S_WR_WR) begin
      mem_we          = 1'b1;
      mem_wd[wr_gx_r] = wr_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr];
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    radius_nxt     = radius_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    cur_valid_nxt  = cur_valid_r;
    count_nxt      = count_r;
    stat_nxt       = stat_r;
    emit_nxt       = emit_r;
    mode_step_nxt  = mode_step_r;
    mv_left_nxt    = mv_left_r;
    mv_down_nxt    = mv_down_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    pend_valid_nxt = 1'b0;
    pend_in_nxt    = probe_in;
    pend_sub_nxt   = probe_sub;
    pend_col_nxt   = px_s[GX_W-1:0];
    wr_gx_nxt      = wr_gx_r;
    wr_gy_nxt      = wr_gy_r;
    wr_val_nxt     = wr_val_r;
    wr_hit_nxt     = wr_hit_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    out_q_nxt      = out_q_r;

    // result register drains on transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // radius register write
    if (cfg_wr && cfg_hit) begin
      radius_nxt = pwdata[2:0];
    end

    // accumulate the cell read for the previous probe
    if (pend_valid_r && pend_in_r && mem_q_r[pend_col_r]) begin
      count_nxt = pend_sub_r ? count_r - CNT_W'(1) : count_r + CNT_W'(1);
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + GY_W'(1);
        if (clr_r == GY_W'(GRID_H - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        u_nxt = '0;
        v_nxt = '0;
        if (cfg_wr && cfg_hit && cur_valid_r) begin
          // new radius: recount without a result
          count_nxt     = '0;
          mode_step_nxt = 1'b0;
          emit_nxt      = 1'b0;
          state_nxt     = S_SCAN;
        end else if (in_fire) begin
          emit_nxt  = 1'b1;
          stat_nxt  = swlc_pkg::STAT_OK;
          state_nxt = S_DONE;
          case (in_d.cmd)
            swlc_pkg::CMD_WRITE: begin
              if (!coords_ok) begin
                stat_nxt = swlc_pkg::STAT_BAD_COORD;
              end else begin
                wr_gx_nxt  = gx_in_s[GX_W-1:0];
                wr_gy_nxt  = gy_in_s[GY_W-1:0];
                wr_val_nxt = in_d.cell_value;
                wr_hit_nxt = cur_valid_r && !(ox_s == 0 && oy_s == 0) &&
                             (ox_s >= -r_s) && (ox_s <= r_s) &&
                             (oy_s >= -r_s) && (oy_s <= r_s);
                state_nxt  = S_WR_RD;
              end
            end
            swlc_pkg::CMD_SET: begin
              if (!coords_ok) begin
                stat_nxt = swlc_pkg::STAT_BAD_COORD;
              end else begin
                cur_x_nxt     = LOC_W'(in_d.cell_x);
                cur_y_nxt     = LOC_W'(in_d.cell_y);
                cur_col_nxt   = CC_W'(in_d.chunk_col);
                cur_row_nxt   = CR_W'(in_d.chunk_row);
                cur_valid_nxt = 1'b1;
                count_nxt     = '0;
                mode_step_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            swlc_pkg::CMD_RIGHT, swlc_pkg::CMD_LEFT, swlc_pkg::CMD_DOWN: begin
              mv_left_nxt   = (in_d.cmd == swlc_pkg::CMD_LEFT);
              mv_down_nxt   = (in_d.cmd == swlc_pkg::CMD_DOWN);
              mode_step_nxt = 1'b1;
              if (!cur_valid_r) begin
                stat_nxt = swlc_pkg::STAT_NOT_SET;
              end else if ((in_d.cmd == swlc_pkg::CMD_RIGHT &&
                            cur_x_r == LOC_W'(CHUNK_SIDE - 1)) ||
                           (in_d.cmd == swlc_pkg::CMD_LEFT && cur_x_r == '0) ||
                           (in_d.cmd == swlc_pkg::CMD_DOWN &&
                            cur_y_r == LOC_W'(CHUNK_SIDE - 1))) begin
                stat_nxt = swlc_pkg::STAT_EDGE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              stat_nxt = swlc_pkg::STAT_OK;
            end
          endcase
        end
      end
      S_WR_RD: begin
        state_nxt = S_WR_WR;
      end
      S_WR_WR: begin
        // keep the count exact when a cell inside the square changes
        if (wr_hit_r && (old_bit != wr_val_r)) begin
          count_nxt = wr_val_r ? count_r + CNT_W'(1) : count_r - CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        pend_valid_nxt = 1'b1;
        if (v_r == v_max) begin
          v_nxt = '0;
          u_nxt = u_r + U_W'(1);
        end else begin
          v_nxt = v_r + U_W'(1);
        end
        if (probe_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last probe lands this cycle; move the cursor after a step
        if (mode_step_r && emit_r) begin
          if (mv_down_r) begin
            cur_y_nxt = cur_y_r + LOC_W'(1);
          end else if (mv_left_r) begin
            cur_x_nxt = cur_x_r - LOC_W'(1);
          end else begin
            cur_x_nxt = cur_x_r + LOC_W'(1);
          end
        end
        state_nxt = emit_r ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_q_nxt.live_count = 7'(count_r);
          out_q_nxt.cursor_x   = 4'(cur_x_r);
          out_q_nxt.cursor_y   = 4'(cur_y_r);
          out_q_nxt.status     = stat_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      radius_r     <= swlc_pkg::RADIUS_RST;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      cur_valid_r  <= 1'b0;
      count_r      <= '0;
      stat_r       <= swlc_pkg::STAT_OK;
      emit_r       <= 1'b0;
      mode_step_r  <= 1'b0;
      mv_left_r    <= 1'b0;
      mv_down_r    <= 1'b0;
      u_r          <= '0;
      v_r          <= '0;
      pend_valid_r <= 1'b0;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      radius_r     <= radius_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_valid_r  <= cur_valid_nxt;
      count_r      <= count_nxt;
      stat_r       <= stat_nxt;
      emit_r       <= emit_nxt;
      mode_step_r  <= mode_step_nxt;
      mv_left_r    <= mv_left_nxt;
      mv_down_r    <= mv_down_nxt;
      u_r          <= u_nxt;
      v_r          <= v_nxt;
      pend_valid_r <= pend_valid_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_in_r  <= pend_in_nxt;
    pend_sub_r <= pend_sub_nxt;
    pend_col_r <= pend_col_nxt;
    wr_gx_r    <= wr_gx_nxt;
    wr_gy_r    <= wr_gy_nxt;
    wr_val_r   <= wr_val_nxt;
    wr_hit_r   <= wr_hit_nxt;
    out_q_r    <= out_q_nxt;
  end

  // one item in flight: after an input transfer the port closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  // a result appears only out of the result state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result register loaded outside the result state");

  // the running count never leaves the size of the square when idle
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r <= CNT_W'(N_SQ - 1)))
    else $error("running count beyond the square size");

  // cursor-not-set status only while no cursor is set
  a_not_set_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && stat_r == swlc_pkg::STAT_NOT_SET) |-> !cur_valid_r)
    else $error("cursor-not-set status with a valid cursor");

endmodule
